// ----- sv/assert_macros.svh -----
// Assertion macros used by the port checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define PNV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define PNV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pnv_pkg.sv -----
// Package: widths, codes, config type and helpers for the chiptune voice.
package pnv_pkg;

    localparam int PHASE_BITS  = 24;
    localparam int TICK_BITS   = 16;
    localparam int LEVEL_BITS  = 15;
    localparam int SAMPLE_BITS = LEVEL_BITS + 1;
    localparam int STEP_BITS   = 24;
    localparam int KIND_BITS   = 3;
    localparam int DUTY_BITS   = 2;
    localparam int IDX_BITS    = 3;
    localparam int DATA_BITS   = 16;
    localparam int LFSR_BITS   = 15;
    // env tick counter carries one extra bit over the config length
    localparam int ENV_T_BITS  = TICK_BITS + 1;
    // numerator of every envelope division: level times a tick count
    localparam int NUM_BITS    = LEVEL_BITS + TICK_BITS;
    localparam int DIV_CNT_BITS = $clog2(LEVEL_BITS + 1);

    localparam logic [LEVEL_BITS-1:0] FULL_LEVEL   = {LEVEL_BITS{1'b1}};
    localparam logic [LEVEL_BITS-1:0] SILENT_LEVEL = LEVEL_BITS'(32);
    localparam logic [ENV_T_BITS-1:0] TICKS_MAX    = {ENV_T_BITS{1'b1}};
    localparam logic [LFSR_BITS-1:0]  LFSR_RESET   = {LFSR_BITS{1'b1}};

    // Input item kinds
    localparam logic [KIND_BITS-1:0] K_TICK      = 3'd0;
    localparam logic [KIND_BITS-1:0] K_NOTE_ON   = 3'd1;
    localparam logic [KIND_BITS-1:0] K_NOTE_OFF  = 3'd2;
    localparam logic [KIND_BITS-1:0] K_SET_PITCH = 3'd3;
    localparam logic [KIND_BITS-1:0] K_SET_DUTY  = 3'd4;

    // Config register indexes
    localparam logic [IDX_BITS-1:0] R_ATTACK  = 3'd0;
    localparam logic [IDX_BITS-1:0] R_DECAY   = 3'd1;
    localparam logic [IDX_BITS-1:0] R_SUSTAIN = 3'd2;
    localparam logic [IDX_BITS-1:0] R_RELEASE = 3'd3;
    localparam logic [IDX_BITS-1:0] R_NOISE   = 3'd4;

    // Duty codes
    localparam logic [DUTY_BITS-1:0] D_12 = 2'd0;
    localparam logic [DUTY_BITS-1:0] D_25 = 2'd1;
    localparam logic [DUTY_BITS-1:0] D_50 = 2'd2;
    localparam logic [DUTY_BITS-1:0] D_75 = 2'd3;

    typedef struct packed {
        logic [TICK_BITS-1:0]  attack;
        logic [TICK_BITS-1:0]  decay;
        logic [LEVEL_BITS-1:0] sustain;
        logic [TICK_BITS-1:0]  rel;
        logic                  noise_mode;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic note_on;
        logic note_off;
    } env_cmd_t;

    typedef struct packed {
        logic                  done;
        logic [LEVEL_BITS-1:0] level;
        logic                  gate;
    } env_stat_t;

    // Pulse is high while the phase lies below the duty threshold;
    // thresholds are whole eighths, so the top three phase bits decide.
    function automatic logic pulse_high(input logic [2:0] eighth,
                                        input logic [DUTY_BITS-1:0] duty);
        logic hi;
        begin
            hi = 1'b0;
            unique case (duty)
                D_12: hi = (eighth < 3'd1);
                D_25: hi = (eighth < 3'd2);
                D_50: hi = (eighth < 3'd4);
                D_75: hi = (eighth < 3'd6);
                default: hi = 1'b0;
            endcase
            return hi;
        end
    endfunction

endpackage

// ----- sv/pnv_if.sv -----
// Channel interfaces: input item, result item and config write.
interface pnv_item_if import pnv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  kind;
    logic [STEP_BITS-1:0]  phase_step;
    logic [DUTY_BITS-1:0]  duty;

    modport source (output valid, kind, phase_step, duty, input ready);
    modport sink   (input valid, kind, phase_step, duty, output ready);
endinterface

interface pnv_result_if import pnv_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [LEVEL_BITS-1:0]         level_out;
    logic                          sounding;

    modport source (output valid, sample_out, level_out, sounding, input ready);
    modport sink   (input valid, sample_out, level_out, sounding, output ready);
endinterface

interface pnv_cfg_if import pnv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IDX_BITS-1:0]  index;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/pnv_div.sv -----
// Shared restoring divider: one quotient bit per cycle for the envelope.
module pnv_div import pnv_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_BITS-1:0]   num,
    input  logic [TICK_BITS-1:0]  den,
    output logic                  done,
    output logic [LEVEL_BITS-1:0] quotient
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [TICK_BITS-1:0]    rem_reg, rem_next;
    logic [LEVEL_BITS-1:0]   quo_reg, quo_next;
    logic [TICK_BITS-1:0]    den_reg, den_next;
    logic [TICK_BITS:0]      shifted;
    logic [TICK_BITS+1:0]    trial;

    // Trial subtract of the divisor from the remainder with the next bit in
    assign shifted = {rem_reg, quo_reg[LEVEL_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            // quotient is known to fit, so the top part is below the divisor
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(LEVEL_BITS);
            rem_next  = num[NUM_BITS-1:LEVEL_BITS];
            quo_next  = num[LEVEL_BITS-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (!trial[TICK_BITS+1])
            begin
                rem_next = trial[TICK_BITS-1:0];
            end
            else
            begin
                rem_next = shifted[TICK_BITS-1:0];
            end
            quo_next = {quo_reg[LEVEL_BITS-2:0], ~trial[TICK_BITS+1]};
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/pnv_env.sv -----
// ADSR envelope sequencer: tick counter, one multiplier and the shared divider.
module pnv_env import pnv_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  env_cmd_t  cmd,
    output env_stat_t stat
);

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_SEL  = 2'd1;
    localparam logic [1:0] E_DIV  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [ENV_T_BITS-1:0] ticks_reg, ticks_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic                  gate_reg, gate_next;
    logic                  rel_reg, rel_next;
    logic                  decay_reg, decay_next;
    logic                  done_reg, done_next;

    logic [ENV_T_BITS-1:0] a_ext, d_ext, r_ext, ad_sum;
    logic [ENV_T_BITS-1:0] t_minus_a, r_minus_t;
    logic [LEVEL_BITS-1:0] mul_a;
    logic [TICK_BITS-1:0]  mul_b;
    logic [NUM_BITS-1:0]   product;
    logic                  div_start;
    logic [TICK_BITS-1:0]  div_den;
    logic                  div_done;
    logic [LEVEL_BITS-1:0] div_q;

    assign a_ext     = {1'b0, cfg.attack};
    assign d_ext     = {1'b0, cfg.decay};
    assign r_ext     = {1'b0, cfg.rel};
    assign ad_sum    = a_ext + d_ext;
    assign t_minus_a = ticks_reg - a_ext;
    assign r_minus_t = r_ext - ticks_reg;
    assign product   = NUM_BITS'(mul_a) * NUM_BITS'(mul_b);

    always_comb
    begin
        state_next = state_reg;
        ticks_next = ticks_reg;
        level_next = level_reg;
        gate_next  = gate_reg;
        rel_next   = rel_reg;
        decay_next = decay_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        div_den    = cfg.attack;
        mul_a      = FULL_LEVEL;
        mul_b      = ticks_reg[TICK_BITS-1:0];
        unique case (state_reg)
            E_IDLE:
            begin
                priority if (cmd.note_on)
                begin
                    ticks_next = '0;
                    level_next = '0;
                    gate_next  = 1'b1;
                    rel_next   = 1'b0;
                end
                else if (cmd.note_off)
                begin
                    rel_next   = 1'b1;
                    ticks_next = '0;
                end
                else if (cmd.tick)
                begin
                    if (!gate_reg && (level_reg <= SILENT_LEVEL))
                    begin
                        // closed and nearly silent: drop to zero, keep the count
                        level_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        if (ticks_reg != TICKS_MAX)
                        begin
                            ticks_next = ticks_reg + ENV_T_BITS'(1);
                        end
                        state_next = E_SEL;
                    end
                end
            end
            E_SEL:
            begin
                // pick the stage, form a numerator, start the divider if needed
                priority if (!rel_reg && (ticks_reg < a_ext))
                begin
                    mul_a      = FULL_LEVEL;
                    mul_b      = ticks_reg[TICK_BITS-1:0];
                    div_den    = cfg.attack;
                    div_start  = 1'b1;
                    decay_next = 1'b0;
                    state_next = E_DIV;
                end
                else if (!rel_reg && (ticks_reg < ad_sum))
                begin
                    mul_a      = FULL_LEVEL - cfg.sustain;
                    mul_b      = t_minus_a[TICK_BITS-1:0];
                    div_den    = cfg.decay;
                    div_start  = 1'b1;
                    decay_next = 1'b1;
                    state_next = E_DIV;
                end
                else if (!rel_reg)
                begin
                    level_next = cfg.sustain;
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
                else if (ticks_reg < r_ext)
                begin
                    mul_a      = cfg.sustain;
                    mul_b      = r_minus_t[TICK_BITS-1:0];
                    div_den    = cfg.rel;
                    div_start  = 1'b1;
                    decay_next = 1'b0;
                    state_next = E_DIV;
                end
                else
                begin
                    // release finished: silence and close the gate
                    level_next = '0;
                    gate_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
            end
            E_DIV:
            begin
                if (div_done)
                begin
                    level_next = decay_reg ? (FULL_LEVEL - div_q) : div_q;
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    pnv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (product),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // Advance envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            ticks_reg <= '0;
            level_reg <= '0;
            gate_reg  <= 1'b0;
            rel_reg   <= 1'b0;
            decay_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ticks_reg <= ticks_next;
            level_reg <= level_next;
            gate_reg  <= gate_next;
            rel_reg   <= rel_next;
            decay_reg <= decay_next;
            done_reg  <= done_next;
        end
    end

    assign stat.done  = done_reg;
    assign stat.level = level_reg;
    assign stat.gate  = gate_reg;

endmodule

// ----- sv/pulse_noise_voice_adsr.sv -----
// Top level: one chiptune voice with pulse/noise oscillator and ADSR envelope.
//
//   channel | dir | payload                              | role
//   item    | in  | kind, phase_step, duty               | tick and note commands
//   result  | out | sample_out, level_out, sounding      | one per tick item
//   cfg     | in  | index, data                          | envelope and mode registers
//
// A tick steps the oscillator on transfer, then the envelope picks its stage and
// multiplies, the shared divider forms the level and the level is registered. A
// tick that holds sustain or ends the release skips the divider; one on a closed,
// silent voice skips the stage pick too. Other kinds give no result. item.ready
// is low while a tick is in work or its result waits for the slot, which frees
// as soon as its result transfers. cfg is always ready; reset loads defaults.
module pulse_noise_voice_adsr import pnv_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    pnv_item_if.sink     item,
    pnv_result_if.source result,
    pnv_cfg_if.sink      cfg
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]            state_reg, state_next;
    cfg_t                  cfg_reg, cfg_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [PHASE_BITS-1:0] step_reg, step_next;
    logic [DUTY_BITS-1:0]  duty_reg, duty_next;
    logic [LFSR_BITS-1:0]  lfsr_reg, lfsr_next;
    logic                  pos_reg, pos_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [LEVEL_BITS-1:0]         level_reg, level_next;
    logic                          sound_reg, sound_next;

    logic                  item_xfer;
    logic [PHASE_BITS:0]   phase_sum;
    logic                  wrapped;
    logic [LFSR_BITS-1:0]  lfsr_step;
    logic                  slot_free;
    logic [SAMPLE_BITS-1:0] mag;
    env_cmd_t              env_cmd;
    env_stat_t             env_stat;

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign item_xfer  = item.valid && item.ready;
    assign slot_free  = !out_valid_reg || result.ready;

    // Oscillator step: phase add with carry, LFSR shift on wrap
    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_reg};
    assign wrapped   = phase_sum[PHASE_BITS];
    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[1], lfsr_reg[LFSR_BITS-1:1]};
    assign mag       = {1'b0, env_stat.level};

    assign env_cmd.tick     = item_xfer && (item.kind == K_TICK);
    assign env_cmd.note_on  = item_xfer && (item.kind == K_NOTE_ON);
    assign env_cmd.note_off = item_xfer && (item.kind == K_NOTE_OFF);

    // Config register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                R_ATTACK:  cfg_next.attack     = cfg.data[TICK_BITS-1:0];
                R_DECAY:   cfg_next.decay      = cfg.data[TICK_BITS-1:0];
                R_SUSTAIN: cfg_next.sustain    = cfg.data[LEVEL_BITS-1:0];
                R_RELEASE: cfg_next.rel        = cfg.data[TICK_BITS-1:0];
                R_NOISE:   cfg_next.noise_mode = cfg.data[0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    // Command decode, oscillator update and result hand-off
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        duty_next      = duty_reg;
        lfsr_next      = lfsr_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !result.ready;
        sample_next    = sample_reg;
        level_next     = level_reg;
        sound_next     = sound_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    unique case (item.kind)
                        K_TICK:
                        begin
                            phase_next = phase_sum[PHASE_BITS-1:0];
                            if (cfg_reg.noise_mode)
                            begin
                                if (wrapped)
                                begin
                                    lfsr_next = lfsr_step;
                                    pos_next  = lfsr_step[0];
                                end
                                else
                                begin
                                    pos_next = lfsr_reg[0];
                                end
                            end
                            else
                            begin
                                pos_next = pulse_high(phase_sum[PHASE_BITS-1:PHASE_BITS-3],
                                                      duty_reg);
                            end
                            state_next = S_BUSY;
                        end
                        K_NOTE_ON:   step_next = PHASE_BITS'(item.phase_step);
                        K_NOTE_OFF:  step_next = step_reg;
                        K_SET_PITCH: step_next = PHASE_BITS'(item.phase_step);
                        K_SET_DUTY:  duty_next = item.duty;
                        default:     step_next = step_reg;
                    endcase
                end
            end
            S_BUSY:
            begin
                if (env_stat.done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = pos_reg ? $signed(mag) : -$signed(mag);
                    level_next     = env_stat.level;
                    sound_next     = env_stat.gate;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    pnv_env u_env (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .cmd   (env_cmd),
        .stat  (env_stat)
    );

    // Control and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            cfg_reg.attack     <= TICK_BITS'(160);
            cfg_reg.decay      <= TICK_BITS'(1600);
            cfg_reg.sustain    <= LEVEL_BITS'(19660);
            cfg_reg.rel        <= TICK_BITS'(2400);
            cfg_reg.noise_mode <= 1'b0;
            phase_reg          <= '0;
            step_reg           <= '0;
            duty_reg           <= D_25;
            lfsr_reg           <= LFSR_RESET;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            duty_reg      <= duty_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload and pending sign
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        sample_reg <= sample_next;
        level_reg  <= level_next;
        sound_reg  <= sound_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = sample_reg;
    assign result.level_out  = level_reg;
    assign result.sounding   = sound_reg;

endmodule

// ----- sv/pnv_checker.sv -----
// Port checker for the voice, bound to the top level.
`include "assert_macros.svh"

module pnv_checker import pnv_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [KIND_BITS-1:0]   in_kind,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] sample_out,
    input logic [LEVEL_BITS-1:0]  level_out,
    input logic                   sounding
);

    logic [SAMPLE_BITS-1:0] mag_pos;
    logic [SAMPLE_BITS-1:0] mag_neg;

    assign mag_pos = SAMPLE_BITS'(level_out);
    assign mag_neg = -mag_pos;

    // A stalled result holds its payload
    `PNV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(level_out), "result changed while stalled")

    // Sample is plus or minus the reported level
    `PNV_ASSERT(a_sample_mag, clk, rst_n, !out_valid || (sample_out == mag_pos) || (sample_out == mag_neg), "sample magnitude differs from level")

    // A closed gate always reports silence
    `PNV_ASSERT(a_closed_silent, clk, rst_n, !(out_valid && !sounding) || (level_out == '0), "closed gate with nonzero level")

    // A tick transfer occupies the block
    `PNV_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_valid && in_ready && (in_kind == K_TICK), !in_ready, "ready after tick transfer")

endmodule

bind pulse_noise_voice_adsr pnv_checker u_pnv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_kind    (item.kind),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .sample_out (result.sample_out),
    .level_out  (result.level_out),
    .sounding   (result.sounding)
);

// ----- bench/pnv_voice_checker.sv -----
// Scoreboard for the chiptune voice: mirrors the voice state and checks every result transfer.
module pnv_voice_checker import pnv_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    pnv_item_if    item,
    pnv_result_if  result,
    pnv_cfg_if     cfg,
    output int     mismatches,
    output int     awaiting
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] wave;
        logic [LEVEL_BITS-1:0]         level;
        logic                          sounding;
    } voice_out_t;

    voice_out_t voice_out_q[$];
    voice_out_t got, want;
    int         fail_count;
    int         result_count;

    // Mirrored envelope and mode registers
    logic [TICK_BITS-1:0]  atk_len, dcy_len, rls_len;
    logic [LEVEL_BITS-1:0] sus_lvl;
    logic                  noise_on;

    // Mirrored voice state
    logic [PHASE_BITS-1:0] phase_acc, inc_held;
    logic [DUTY_BITS-1:0]  duty_sel;
    logic [LFSR_BITS-1:0]  lfsr;
    logic [ENV_T_BITS-1:0] env_t;
    logic [LEVEL_BITS-1:0] env_lvl;
    logic                  gate, releasing;

    // Phase below which the pulse is high
    function automatic logic [PHASE_BITS-1:0] duty_edge(input logic [DUTY_BITS-1:0] d);
        case (d)
            D_12:    return PHASE_BITS'(1) << (PHASE_BITS - 3);
            D_25:    return PHASE_BITS'(2) << (PHASE_BITS - 3);
            D_50:    return PHASE_BITS'(4) << (PHASE_BITS - 3);
            default: return PHASE_BITS'(6) << (PHASE_BITS - 3);
        endcase
    endfunction

    // Advance the linear envelope by one tick
    function automatic void step_envelope();
        longint unsigned t, a, d, s, r;
        a = atk_len;
        d = dcy_len;
        s = sus_lvl;
        r = rls_len;
        if (!gate && env_lvl <= SILENT_LEVEL)
        begin
            env_lvl = '0;
            return;
        end
        if (env_t != TICKS_MAX)
            env_t = env_t + 1'b1;
        t = env_t;
        if (!releasing)
        begin
            if (t < a)
                env_lvl = LEVEL_BITS'((t * FULL_LEVEL) / a);
            else if (t < a + d)
                env_lvl = LEVEL_BITS'(FULL_LEVEL - ((FULL_LEVEL - s) * (t - a)) / d);
            else
                env_lvl = LEVEL_BITS'(s);
        end
        else if (t < r)
        begin
            env_lvl = LEVEL_BITS'((s * (r - t)) / r);
        end
        else
        begin
            env_lvl = '0;
            gate    = 1'b0;
        end
    endfunction

    // Apply one accepted item; a tick queues the result it must produce
    function automatic void apply_item(input logic [KIND_BITS-1:0] kind,
                                       input logic [STEP_BITS-1:0] inc,
                                       input logic [DUTY_BITS-1:0] duty);
        logic [PHASE_BITS:0] sum;
        logic                high;
        voice_out_t          next;
        case (kind)
            K_NOTE_ON:
            begin
                inc_held  = inc;
                env_t     = '0;
                env_lvl   = '0;
                gate      = 1'b1;
                releasing = 1'b0;
            end
            K_NOTE_OFF:
            begin
                releasing = 1'b1;
                env_t     = '0;
            end
            K_SET_PITCH:
                inc_held = inc;
            K_SET_DUTY:
                duty_sel = duty;
            K_TICK:
            begin
                sum       = {1'b0, phase_acc} + {1'b0, inc_held};
                phase_acc = sum[PHASE_BITS-1:0];
                if (noise_on)
                begin
                    // step the LFSR on a phase wrap
                    if (sum[PHASE_BITS])
                        lfsr = {lfsr[0] ^ lfsr[1], lfsr[LFSR_BITS-1:1]};
                    high = lfsr[0];
                end
                else
                begin
                    high = phase_acc < duty_edge(duty_sel);
                end
                step_envelope();
                next.level    = env_lvl;
                next.sounding = gate;
                next.wave     = high ? $signed({1'b0, env_lvl}) : -$signed({1'b0, env_lvl});
                voice_out_q.push_back(next);
            end
            default:
                ;
        endcase
    endfunction

    // Mirror a register write; unknown indexes are dropped
    function automatic void write_reg(input logic [IDX_BITS-1:0] idx,
                                      input logic [DATA_BITS-1:0] value);
        case (idx)
            R_ATTACK:  atk_len  = value[TICK_BITS-1:0];
            R_DECAY:   dcy_len  = value[TICK_BITS-1:0];
            R_SUSTAIN: sus_lvl  = value[LEVEL_BITS-1:0];
            R_RELEASE: rls_len  = value[TICK_BITS-1:0];
            R_NOISE:   noise_on = value[0];
            default:   ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_out_q.delete();
            fail_count   = 0;
            result_count = 0;
            atk_len      = TICK_BITS'(160);
            dcy_len      = TICK_BITS'(1600);
            sus_lvl      = LEVEL_BITS'(19660);
            rls_len      = TICK_BITS'(2400);
            noise_on     = 1'b0;
            phase_acc    = '0;
            inc_held     = '0;
            duty_sel     = D_25;
            lfsr         = LFSR_RESET;
            env_t        = '0;
            env_lvl      = '0;
            gate         = 1'b0;
            releasing    = 1'b0;
            mismatches  <= 0;
            awaiting    <= 0;
        end
        else
        begin
            // Compare a result transfer with the oldest expectation
            if (result.valid && result.ready)
            begin
                got.wave     = result.sample_out;
                got.level    = result.level_out;
                got.sounding = result.sounding;
                if (voice_out_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("result %0d with nothing expected: sample %0d level %0d sounding %0b",
                                 result_count, got.wave, got.level, got.sounding);
                end
                else
                begin
                    want = voice_out_q.pop_front();
                    if (got.wave !== want.wave || got.level !== want.level ||
                        got.sounding !== want.sounding)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"result %0d mismatch: sample %0d expected %0d, ",
                                      "level %0d expected %0d, sounding %0b expected %0b"},
                                     result_count, got.wave, want.wave, got.level, want.level,
                                     got.sounding, want.sounding);
                    end
                end
                result_count++;
            end
            if (cfg.valid && cfg.ready)
                write_reg(cfg.index, cfg.data);
            if (item.valid && item.ready)
                apply_item(item.kind, item.phase_step, item.duty);
            mismatches <= fail_count;
            awaiting   <= voice_out_q.size();
        end
    end

endmodule

// ----- bench/pulse_noise_voice_adsr_test.sv -----
// Testbench top: drives note, tick and register traffic into the voice and gives the verdict.
module pulse_noise_voice_adsr_test import pnv_pkg::*;;

    localparam int IDLE_PCT     = 28;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 170;
    localparam logic [IDX_BITS-1:0] R_SPARE = R_NOISE + 3'd1;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   awaiting;
    int   quiet_cycles = 0;
    int   items_sent   = 0;
    int   hold_max     = 30;
    int   tail_max     = 16;
    bit   calm         = 1'b0;

    pnv_item_if   item();
    pnv_result_if result();
    pnv_cfg_if    cfg();

    pulse_noise_voice_adsr u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    pnv_voice_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg        (cfg),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the result side at random unless in a calm stretch
    always @(negedge clk)
        result.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Drop the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(input logic [KIND_BITS-1:0] kind,
                             input logic [STEP_BITS-1:0] inc,
                             input logic [DUTY_BITS-1:0] duty);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item.valid <= 1'b0;
            @(negedge clk);
        end
        item.valid      <= 1'b1;
        item.kind       <= kind;
        item.phase_step <= inc;
        item.duty       <= duty;
        do
            @(posedge clk);
        while (!item.ready);
        if (kind <= K_SET_DUTY)
            items_sent++;
    endtask

    // Mix slow, wrapping, near-full and random pitch steps
    function automatic logic [STEP_BITS-1:0] pick_step();
        case ($urandom_range(0, 3))
            0:       return STEP_BITS'($urandom_range(0, 4095));
            1:       return STEP_BITS'($urandom);
            2:       return ~STEP_BITS'($urandom_range(0, 4095));
            default: return STEP_BITS'($urandom_range(24'h100000, 24'h800000));
        endcase
    endfunction

    // Drop valid and wait until every result is back and the voice is quiet
    task automatic settle();
        @(negedge clk);
        item.valid <= 1'b0;
        wait (awaiting == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
    endtask

    // Reprogram every register on an idle voice, plus one unmapped index
    task automatic load_envelope(input logic [DATA_BITS-1:0] a, input logic [DATA_BITS-1:0] d,
                                 input logic [DATA_BITS-1:0] s, input logic [DATA_BITS-1:0] r,
                                 input logic [DATA_BITS-1:0] n);
        settle();
        write_reg(R_SPARE, DATA_BITS'($urandom));
        write_reg(R_ATTACK, a);
        write_reg(R_DECAY, d);
        write_reg(R_SUSTAIN, s);
        write_reg(R_RELEASE, r);
        write_reg(R_NOISE, n);
        @(negedge clk);
        cfg.valid <= 1'b0;
        hold_max = (int'(a) + int'(d) < 24) ? int'(a) + int'(d) + 6 : 30;
        tail_max = (int'(r) < 16) ? int'(r) + 8 : 16;
    endtask

    // Tick while a note plays, now and then retune or change duty
    task automatic hold_tick();
        case ($urandom_range(0, 19))
            0:       send_item(K_SET_PITCH, pick_step(), DUTY_BITS'($urandom));
            1:       send_item(K_SET_DUTY, STEP_BITS'($urandom), DUTY_BITS'($urandom));
            default: send_item(K_TICK, STEP_BITS'($urandom), DUTY_BITS'($urandom));
        endcase
    endtask

    // Note on, hold through attack and decay, release and ring out
    task automatic play_note();
        int n;
        if ($urandom_range(0, 4) == 0)
            send_item(K_SET_DUTY, pick_step(), DUTY_BITS'($urandom));
        send_item(K_NOTE_ON, pick_step(), DUTY_BITS'($urandom));
        n = $urandom_range(1, hold_max);
        repeat (n) hold_tick();
        send_item(K_NOTE_OFF, STEP_BITS'($urandom), DUTY_BITS'($urandom));
        n = $urandom_range(0, tail_max);
        repeat (n) hold_tick();
    endtask

    // Random kinds in any order, unknown kinds among them
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_item(KIND_BITS'($urandom), STEP_BITS'($urandom), DUTY_BITS'($urandom));
    endtask

    task automatic run_phase(input int goal);
        int stop;
        stop = items_sent + goal;
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                play_note();
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        item.valid      = 1'b0;
        item.kind       = K_TICK;
        item.phase_step = '0;
        item.duty       = D_12;
        cfg.valid       = 1'b0;
        cfg.index       = R_ATTACK;
        cfg.data        = '0;
        result.ready    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: silent voice, every duty, pitch extremes, unknown kinds
        send_item(K_TICK, '1, '1);
        send_item(K_SET_PITCH, '1, D_12);
        send_item(K_SET_DUTY, '0, D_12);
        send_item(K_NOTE_ON, '1, D_75);
        repeat (2) send_item(K_TICK, '0, '0);
        send_item(K_SET_DUTY, '0, D_25);
        send_item(K_TICK, '0, '0);
        send_item(K_SET_DUTY, '0, D_50);
        send_item(K_TICK, '0, '0);
        send_item(K_SET_DUTY, '0, D_75);
        send_item(K_TICK, '0, '0);
        send_item(K_SET_PITCH, '0, D_12);
        send_item(K_TICK, '1, '1);
        send_item(K_SET_PITCH, 24'h200000, D_12);
        repeat (2) send_item(K_TICK, '0, '0);
        send_item(K_NOTE_OFF, '0, '0);
        repeat (2) send_item(K_TICK, '0, '0);
        for (int k = K_SET_DUTY + 1; k < (1 << KIND_BITS); k++)
            send_item(KIND_BITS'(k), '1, '1);
        send_item(K_TICK, '0, '0);

        // Zero lengths in noise mode: skip attack and decay, end at the next tick
        load_envelope('0, '0, '1, '0, '1);
        send_item(K_NOTE_ON, 24'h800000, D_50);
        repeat (3) send_item(K_TICK, '0, '0);
        send_item(K_NOTE_OFF, '0, '0);
        repeat (3) send_item(K_TICK, '0, '0);

        // Calm stretch with short stages and full sustain
        load_envelope(16'd4, 16'd6, 16'h7FFF, 16'd6, '0);
        calm = 1'b1;
        run_phase(PHASE_ITEMS);
        calm = 1'b0;

        // Shortest nonzero stages, silent sustain
        load_envelope(16'd1, 16'd1, '0, 16'd1, '1);
        run_phase(PHASE_ITEMS);

        repeat (4)
        begin
            load_envelope(DATA_BITS'($urandom_range(0, 8)), DATA_BITS'($urandom_range(0, 10)),
                          DATA_BITS'($urandom), DATA_BITS'($urandom_range(0, 10)),
                          DATA_BITS'($urandom));
            run_phase(PHASE_ITEMS);
        end

        // Longest stages: only the start of the attack is reachable
        load_envelope('1, '1, '1, '1, '1);
        run_phase(40);

        settle();
        if (mismatches == 0 && awaiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
